// File: src/cle_pkg.sv
// Shared constants, types and helpers for the console line editor.
package cle_pkg;

    // Line store size and derived widths
    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int LEN_W        = 6;

    // Console key codes
    localparam logic [7:0] KEY_NUL   = 8'd0;
    localparam logic [7:0] KEY_BELL  = 8'd7;
    localparam logic [7:0] KEY_BS    = 8'd8;
    localparam logic [7:0] KEY_LF    = 8'd10;
    localparam logic [7:0] KEY_CR    = 8'd13;
    localparam logic [7:0] KEY_SPACE = 8'd32;
    localparam logic [7:0] KEY_DEL   = 8'd127;

    // Kind of result sequence a request produces
    typedef enum logic [2:0] {
        KIND_READ     = 3'd0,
        KIND_ECHO     = 3'd1,
        KIND_ERASE    = 3'd2,
        KIND_CR_ECHO  = 3'd3,
        KIND_CR_QUIET = 3'd4
    } kind_t;

    // Result plan handed to the output sequencer
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        echo_byte;
        logic [LEN_W-1:0]  line_length;
        logic [7:0]        read_data;
    } plan_t;

    // Low bits of the fill count as a reported line length
    function automatic logic [LEN_W-1:0] to_len(input logic [ADDR_W-1:0] fc);
        logic [ADDR_W+LEN_W-1:0] wide;
        wide = {{LEN_W{1'b0}}, fc};
        return wide[LEN_W-1:0];
    endfunction

endpackage

// File: src/console_line_editor.sv
// Top level of the console line editor: line store, fill count and result sequencing.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: command 0 delivers
//   a received console byte in rx_byte, command 1 reads line store entry
//   read_index. Output channel (out_valid / out_stall) carries result items:
//   echo bytes, the completed-line report and read data, with last marking the
//   final item of a request. Bytes 0 and LF, and echo-only bytes with echo
//   off, produce no items.
//   cfg_write / cfg_data set the echo enable register (reset value one).
// Path: the first item of a request passes the decode register, then the
//   output register; the store read is a registered RAM read.
// Throughput: one request per cycle for requests with one result item while
//   out_stall is low; a request with several items (erase three, CR with echo
//   two) holds the single output register until its last item is delivered.
// Reset: fill count zero, all store entries read as zero (per-entry valid
//   flops cleared at once), echo on. No clearing pass is needed.
// Stall: a stalled result holds; in_stall rises once the decode register is
//   also full, so no request is lost.
module console_line_editor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [7:0]                  rx_byte,
    input  logic [5:0]                  read_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        echo_valid,
    output logic [7:0]                  echo_byte,
    output logic                        line_done,
    output logic [cle_pkg::LEN_W-1:0]   line_length,
    output logic [7:0]                  read_data,
    output logic                        last
);

    localparam int AW = cle_pkg::ADDR_W;
    localparam int BB = cle_pkg::BUFFER_BYTES;

    logic                   echo_en_reg;
    logic [AW-1:0]          fc_reg, fc_next;
    logic [BB-1:0]          ent_valid_reg, ent_valid_next;

    logic                   s1_valid_reg, s1_valid_next;
    cle_pkg::plan_t         s1_plan_reg, plan_d;
    logic                   s1_rd_ok_reg, rd_ok_d;
    logic                   has_items;

    logic                   accept;
    logic                   seq_take;
    cle_pkg::plan_t         seq_plan;

    logic [AW+5:0]          idx_wide;
    logic [AW-1:0]          rd_addr;
    logic                   in_range;
    logic [AW:0]            fc_inc;
    logic [AW-1:0]          fc_dec;
    logic                   room;
    logic                   ram_we;
    logic [7:0]             ram_q;

    assign accept   = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !seq_take;

    // Read address and range check
    assign idx_wide = {{AW{1'b0}}, read_index};
    assign in_range = idx_wide < (AW + 6)'(BB);
    assign rd_addr  = idx_wide[AW-1:0];
    assign rd_ok_d  = in_range && ent_valid_reg[rd_addr];

    assign fc_inc = {1'b0, fc_reg} + {{AW{1'b0}}, 1'b1};
    assign fc_dec = fc_reg - {{(AW-1){1'b0}}, 1'b1};
    assign room   = fc_inc < (AW + 1)'(BB);

    // Request decode and line state update
    always_comb
    begin
        fc_next              = fc_reg;
        ent_valid_next       = ent_valid_reg;
        ram_we               = 1'b0;
        has_items            = 1'b0;
        plan_d.kind          = cle_pkg::KIND_ECHO;
        plan_d.echo_byte     = rx_byte;
        plan_d.line_length   = cle_pkg::to_len(fc_reg);
        plan_d.read_data     = 8'd0;
        if (command)
        begin
            plan_d.kind = cle_pkg::KIND_READ;
            has_items   = 1'b1;
        end
        else if (rx_byte == cle_pkg::KEY_NUL || rx_byte == cle_pkg::KEY_LF)
        begin
            has_items = 1'b0;
        end
        else if (rx_byte == cle_pkg::KEY_CR)
        begin
            ent_valid_next[fc_reg] = 1'b0;
            fc_next                = '0;
            has_items              = 1'b1;
            plan_d.kind            = echo_en_reg ? cle_pkg::KIND_CR_ECHO
                                                 : cle_pkg::KIND_CR_QUIET;
        end
        else if (rx_byte == cle_pkg::KEY_BS || rx_byte == cle_pkg::KEY_DEL)
        begin
            if (fc_reg != '0)
            begin
                fc_next                = fc_dec;
                ent_valid_next[fc_dec] = 1'b0;
                has_items              = echo_en_reg;
                plan_d.kind            = cle_pkg::KIND_ERASE;
            end
        end
        else if (room)
        begin
            ram_we                         = 1'b1;
            ent_valid_next[fc_reg]         = 1'b1;
            ent_valid_next[fc_inc[AW-1:0]] = 1'b0;
            fc_next                        = fc_inc[AW-1:0];
            has_items                      = echo_en_reg;
        end
        else
        begin
            plan_d.echo_byte = cle_pkg::KEY_BELL;
            has_items        = echo_en_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg   <= 1'b1;
            fc_reg        <= '0;
            ent_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                echo_en_reg <= cfg_data;
            end
            if (accept)
            begin
                fc_reg        <= fc_next;
                ent_valid_reg <= ent_valid_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Decode register: filled on accept, emptied when the sequencer takes it
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = has_items;
        end
        else if (seq_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_plan_reg  <= plan_d;
            s1_rd_ok_reg <= rd_ok_d;
        end
    end

    // Line store
    cle_ram #(
        .WIDTH (8),
        .DEPTH (BB)
    ) u_store (
        .clk   (clk),
        .we    (accept && ram_we),
        .waddr (fc_reg),
        .wdata (rx_byte),
        .re    (accept && command),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Merge read data into the plan
    always_comb
    begin
        seq_plan           = s1_plan_reg;
        seq_plan.read_data = s1_rd_ok_reg ? ram_q : 8'd0;
    end

    cle_out_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .plan_valid  (s1_valid_reg),
        .plan        (seq_plan),
        .take        (seq_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .echo_valid  (echo_valid),
        .echo_byte   (echo_byte),
        .line_done   (line_done),
        .line_length (line_length),
        .read_data   (read_data),
        .last        (last)
    );

    // Checks
    a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fc_reg} < (AW + 1)'(BB)))
        else $error("fill count beyond store");

    a_read_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |=> s1_valid_reg)
        else $error("read request produced no plan");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid))
        else $error("input stalled with free decode register");

endmodule

// File: src/cle_ram.sv
// Generic simple dual-port RAM with registered read.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/cle_out_seq.sv
// Output sequencer: turns one result plan into one to three result items.
module cle_out_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        plan_valid,
    input  cle_pkg::plan_t              plan,
    output logic                        take,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        echo_valid,
    output logic [7:0]                  echo_byte,
    output logic                        line_done,
    output logic [cle_pkg::LEN_W-1:0]   line_length,
    output logic [7:0]                  read_data,
    output logic                        last
);

    logic           busy_reg, busy_next;
    logic [1:0]     step_reg, step_next;
    cle_pkg::plan_t plan_reg, plan_next;
    logic           out_fire;

    // Item fields from the held plan and the step within it
    always_comb
    begin
        echo_valid  = 1'b0;
        echo_byte   = 8'd0;
        line_done   = 1'b0;
        line_length = '0;
        read_data   = 8'd0;
        last        = 1'b1;
        case (plan_reg.kind)
            cle_pkg::KIND_READ:
            begin
                read_data = plan_reg.read_data;
            end
            cle_pkg::KIND_ECHO:
            begin
                echo_valid = 1'b1;
                echo_byte  = plan_reg.echo_byte;
            end
            cle_pkg::KIND_ERASE:
            begin
                echo_valid = 1'b1;
                echo_byte  = (step_reg == 2'd1) ? cle_pkg::KEY_SPACE : cle_pkg::KEY_BS;
                last       = (step_reg == 2'd2);
            end
            cle_pkg::KIND_CR_ECHO:
            begin
                echo_valid = 1'b1;
                if (step_reg == 2'd0)
                begin
                    echo_byte = cle_pkg::KEY_CR;
                    last      = 1'b0;
                end
                else
                begin
                    echo_byte   = cle_pkg::KEY_LF;
                    line_done   = 1'b1;
                    line_length = plan_reg.line_length;
                end
            end
            cle_pkg::KIND_CR_QUIET:
            begin
                line_done   = 1'b1;
                line_length = plan_reg.line_length;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    assign out_valid = busy_reg;
    assign out_fire  = busy_reg && !out_stall;
    assign take      = !busy_reg || (out_fire && last);

    // Sequencing: advance on each delivered item, reload after the last
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        plan_next = plan_reg;
        if (out_fire && !last)
        begin
            step_next = step_reg + 2'd1;
        end
        else if (take)
        begin
            busy_next = plan_valid;
            step_next = 2'd0;
            if (plan_valid)
            begin
                plan_next = plan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
    end

    // Checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg != 2'd3))
        else $error("sequencer step out of range");

    a_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg != 2'd0) |->
            (plan_reg.kind == cle_pkg::KIND_ERASE || plan_reg.kind == cle_pkg::KIND_CR_ECHO))
        else $error("multi-item step on a single-item plan");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_stall) |=> (busy_reg && $stable(step_reg)))
        else $error("sequencer moved while stalled");

endmodule

// File: test/tb_console_line_editor.sv
// Testbench for the console line editor: line prediction, random traffic and stall pressure.
module tb_console_line_editor;
    timeunit 1ns;
    timeprecision 1ps;

    // One result item as seen on the output channel
    typedef struct packed {
        logic                      echo_valid;
        logic [7:0]                echo_byte;
        logic                      line_done;
        logic [cle_pkg::LEN_W-1:0] line_length;
        logic [7:0]                read_data;
        logic                      last;
    } echo_item_t;

    // Edit-line predictor plus the queue of results still owed by the block
    class line_editor_board;
        logic [7:0]  line_bytes [cle_pkg::BUFFER_BYTES];
        int unsigned line_fill;
        bit          echo_on;
        echo_item_t  owed_items [$];
        int          errors;

        function new();
            foreach (line_bytes[i])
            begin
                line_bytes[i] = 8'd0;
            end
            line_fill = 0;
            echo_on   = 1'b1;
            errors    = 0;
        endfunction

        function void set_echo(bit on);
            echo_on = on;
        endfunction

        // Work out the result items of one accepted request and queue them
        function void note_request(logic cmd, logic [7:0] rx, logic [5:0] idx);
            echo_item_t seq [$];
            echo_item_t it;
            it = '0;
            if (cmd)
            begin
                it.read_data = (idx < cle_pkg::BUFFER_BYTES) ? line_bytes[idx] : 8'd0;
                seq.push_back(it);
            end
            else if (rx == cle_pkg::KEY_CR)
            begin
                if (line_fill < cle_pkg::BUFFER_BYTES)
                    line_bytes[line_fill] = 8'd0;
                if (echo_on)
                begin
                    it.echo_valid = 1'b1;
                    it.echo_byte  = cle_pkg::KEY_CR;
                    seq.push_back(it);
                    it.echo_byte  = cle_pkg::KEY_LF;
                end
                // line report rides on the LF item, or alone with echo off
                it.line_done   = 1'b1;
                it.line_length = line_fill[cle_pkg::LEN_W-1:0];
                seq.push_back(it);
                line_fill = 0;
            end
            else if (rx == cle_pkg::KEY_BS || rx == cle_pkg::KEY_DEL)
            begin
                if (line_fill > 0)
                begin
                    line_fill--;
                    line_bytes[line_fill] = 8'd0;
                    if (echo_on)
                    begin
                        it.echo_valid = 1'b1;
                        it.echo_byte  = cle_pkg::KEY_BS;
                        seq.push_back(it);
                        it.echo_byte  = cle_pkg::KEY_SPACE;
                        seq.push_back(it);
                        it.echo_byte  = cle_pkg::KEY_BS;
                        seq.push_back(it);
                    end
                end
            end
            else if (rx != cle_pkg::KEY_NUL && rx != cle_pkg::KEY_LF)
            begin
                it.echo_valid = 1'b1;
                if (line_fill + 1 < cle_pkg::BUFFER_BYTES)
                begin
                    line_bytes[line_fill] = rx;
                    line_fill++;
                    line_bytes[line_fill] = 8'd0;
                    it.echo_byte = rx;
                end
                else
                    it.echo_byte = cle_pkg::KEY_BELL;   // line full: byte dropped
                if (echo_on)
                    seq.push_back(it);
            end
            if (seq.size() > 0)
                seq[seq.size() - 1].last = 1'b1;
            foreach (seq[i])
            begin
                owed_items.push_back(seq[i]);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 40)
                $display("%0t ns mismatch: %s", $realtime, what);
        endtask

        task cmp_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // Compare one accepted result with the oldest owed item
        task check_result(echo_item_t got);
            echo_item_t want;
            if (owed_items.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing owed", got));
                return;
            end
            want = owed_items.pop_front();
            cmp_field("echo_valid", 8'(got.echo_valid), 8'(want.echo_valid));
            cmp_field("echo_byte", got.echo_byte, want.echo_byte);
            cmp_field("line_done", 8'(got.line_done), 8'(want.line_done));
            cmp_field("line_length", 8'(got.line_length), 8'(want.line_length));
            cmp_field("read_data", got.read_data, want.read_data);
            cmp_field("last", 8'(got.last), 8'(want.last));
        endtask
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_write  = 1'b0;
    logic                      cfg_data   = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic                      command    = 1'b0;
    logic [7:0]                rx_byte    = 8'd0;
    logic [5:0]                read_index = 6'd0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic                      echo_valid;
    logic [7:0]                echo_byte;
    logic                      line_done;
    logic [cle_pkg::LEN_W-1:0] line_length;
    logic [7:0]                read_data;
    logic                      last;

    line_editor_board board;
    int               requests_sent = 0;
    bit               no_idle       = 1'b0;
    bit               hold_go       = 1'b0;
    int               hold_left     = 0;

    console_line_editor dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Result monitor
    always @(posedge clk)
    begin
        echo_item_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{echo_valid, echo_byte, line_done, line_length, read_data, last};
            board.check_result(got);
        end
    end

    // Receiver: random stalls, or one long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = 200;
                out_stall <= 1'b1;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 17);
        end
    end

    // Offer one request, with random gaps ahead of it, and wait until taken
    task automatic send_request(logic cmd, logic [7:0] rx, logic [5:0] idx);
        while (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        rx_byte    <= rx;
        read_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(cmd, rx, idx);
        if (cmd || (rx != cle_pkg::KEY_NUL && rx != cle_pkg::KEY_LF))
            requests_sent++;
    endtask

    // Any byte the block stores as text
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255, 1));
        while (b == cle_pkg::KEY_BS || b == cle_pkg::KEY_LF || b == cle_pkg::KEY_CR
               || b == cle_pkg::KEY_DEL);
        return b;
    endfunction

    // One edited line: text with erases, reads and noise, then CR and maybe a read-back
    task automatic send_line();
        int len;
        int pick;
        int rd;
        len = ($urandom_range(99) < 4) ? $urandom_range(70, 55) : $urandom_range(12, 0);
        repeat (len)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                send_request(1'b0, text_byte(), 6'($urandom_range(63)));
            else if (pick < 86)
                send_request(1'b0, $urandom_range(1) ? cle_pkg::KEY_BS : cle_pkg::KEY_DEL,
                             6'($urandom_range(63)));
            else if (pick < 92)
                send_request(1'b1, 8'($urandom_range(255)), 6'($urandom_range(63)));
            else
                send_request(1'b0, 8'($urandom_range(255)), 6'($urandom_range(63)));
        end
        send_request(1'b0, cle_pkg::KEY_CR, 6'($urandom_range(63)));
        if ($urandom_range(99) < 30)
        begin
            rd = 0;
            while (rd <= len + 1 && rd < 6)
            begin
                send_request(1'b1, 8'($urandom_range(255)), 6'(rd));
                rd++;
            end
        end
    endtask

    // Let every owed result arrive, then let requests with no result settle as well
    task automatic wait_line_quiet();
        in_valid <= 1'b0;
        while (board.owed_items.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_echo(bit on);
        cfg_write <= 1'b1;
        cfg_data  <= on;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_echo(on);
    endtask

    initial
    begin
        int waited;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset store, ignored bytes, empty erase, text, erase, reads, CR
        send_request(1'b1, 8'hFF, 6'd0);
        send_request(1'b1, 8'h00, 6'd63);
        send_request(1'b0, cle_pkg::KEY_NUL, 6'h3F);
        send_request(1'b0, cle_pkg::KEY_LF, 6'd0);
        send_request(1'b0, cle_pkg::KEY_BS, 6'd0);
        send_request(1'b0, cle_pkg::KEY_DEL, 6'd0);
        send_request(1'b0, 8'd65, 6'd0);
        send_request(1'b0, 8'hFF, 6'd0);
        send_request(1'b0, 8'd1, 6'd0);
        send_request(1'b0, 8'h80, 6'd0);
        send_request(1'b0, cle_pkg::KEY_DEL, 6'd0);
        send_request(1'b0, cle_pkg::KEY_BS, 6'd0);
        send_request(1'b1, 8'h00, 6'd0);
        send_request(1'b1, 8'h00, 6'd1);
        send_request(1'b1, 8'h00, 6'd2);
        send_request(1'b0, cle_pkg::KEY_CR, 6'd0);
        send_request(1'b0, cle_pkg::KEY_CR, 6'd0);
        wait_line_quiet();

        // Echo off: text and erase go silent, CR reports alone
        write_echo(1'b0);
        send_request(1'b0, 8'h7E, 6'd0);
        send_request(1'b0, cle_pkg::KEY_BS, 6'd0);
        send_request(1'b0, cle_pkg::KEY_BS, 6'd0);
        send_request(1'b0, 8'd120, 6'd0);
        send_request(1'b0, cle_pkg::KEY_CR, 6'd0);
        send_request(1'b1, 8'h00, 6'd0);
        wait_line_quiet();
        write_echo(1'b1);

        // Long receiver hold while an overlong line fills the buffer and rings the bell
        hold_go = 1'b1;
        repeat (75) send_request(1'b0, text_byte(), 6'($urandom_range(63)));
        send_request(1'b0, cle_pkg::KEY_CR, 6'd0);
        send_request(1'b1, 8'h00, 6'd62);
        send_request(1'b1, 8'h00, 6'd63);
        while (requests_sent < 150)
            send_line();
        wait_line_quiet();

        write_echo(1'b0);
        while (requests_sent < 200)
            send_line();
        wait_line_quiet();

        // Echo back on, first with neither side idling
        write_echo(1'b1);
        no_idle = 1'b1;
        while (requests_sent < 260)
            send_line();
        no_idle = 1'b0;
        while (requests_sent < 300)
            send_line();

        in_valid <= 1'b0;
        waited = 0;
        while (board.owed_items.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (board.owed_items.size() != 0)
            board.report_mismatch($sformatf("%0d results never came", board.owed_items.size()));
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
